@@ hdl/double_ended_queue_top_macros.svh @@
// assertion macros shared by the deque design
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// property checked every cycle outside reset
`define DEQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence checked in the cycle after the trigger
`define DEQ_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

@@ hdl/deq_pkg.sv @@
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 3;
  localparam int STAT_W     = 2;

  // stream word widths, padded to whole bytes
  localparam int S_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int M_RAW_W   = 2 * DATA_WIDTH + CNT_W + 1 + STAT_W;
  localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

  // value reported for front and back when nothing is stored
  localparam logic [DATA_WIDTH-1:0] EMPTY_MARK = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_STATUS     = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } stat_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_r;    // push front: everything moves one cell back
    logic shift_l;    // pop front: everything moves one cell forward
    logic add_tail;   // first free cell takes the word
    logic drop_tail;  // last occupied cell drops its word
  } cell_ctrl_t;

endpackage

@@ hdl/deq_cell.sv @@
module deq_cell
  import deq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] data_in,
  input  logic [DATA_WIDTH-1:0] left_val,
  input  logic                  left_vld,
  input  logic [DATA_WIDTH-1:0] right_val,
  input  logic                  right_vld,
  output logic [DATA_WIDTH-1:0] val,
  output logic                  vld,
  output logic [DATA_WIDTH-1:0] val_next,
  output logic                  vld_next
);

  // next contents from the command and the two neighbors
  always_comb begin
    val_next = val;
    vld_next = vld;
    if (ctrl.shift_r) begin
      val_next = left_val;
      vld_next = left_vld;
    end else if (ctrl.shift_l) begin
      val_next = right_val;
      vld_next = right_vld;
    end else if (ctrl.add_tail) begin
      if (!vld && left_vld) begin
        val_next = data_in;
        vld_next = 1'b1;
      end
    end else if (ctrl.drop_tail) begin
      if (vld && !right_vld) begin
        vld_next = 1'b0;
      end
    end
  end

  // occupancy bit is control, the word itself is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
    val <= val_next;
  end

endmodule

@@ hdl/double_ended_queue_top.sv @@
// Bounded double-ended queue of DEPTH signed words built as a row of shift
// cells: cell 0 always holds the front, the occupied cells are packed from
// cell 0 upward, and push/pop at the front shifts the whole row by one cell
// while push/pop at the back touches only the cell at the boundary. Every
// operation word on the input gives exactly one result word, registered on
// the output; a new operation is taken every cycle as long as the previous
// result is taken, so throughput is one operation per clock, and the result
// is valid in the cycle after the input handshake. The result shows front and
// back values (largest positive value when empty), the entry count, an empty
// flag and a status: pop on an empty queue and push on a full one leave the
// contents unchanged and are flagged. Operation codes 5 to 7 act as a status
// query. No clearing pass is needed after reset.
module double_ended_queue_top
  import deq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // data_value
  input  logic [OP_W-1:0]      s_tuser,   // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // front_value, back_value, entry_total,
                                          // is_empty, status
);

  logic                  s_acc;
  logic [DATA_WIDTH-1:0] data_in;
  cell_ctrl_t            ctrl;
  stat_t                 stat_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;

  logic [DATA_WIDTH-1:0] val      [DEPTH];
  logic [DATA_WIDTH-1:0] val_next [DEPTH];
  logic [DEPTH-1:0]      vld;
  logic [DEPTH-1:0]      vld_next;
  logic [DEPTH-1:0]      last_mask;
  logic [DATA_WIDTH-1:0] back_sel;
  logic [DATA_WIDTH-1:0] front_sel;

  logic [DATA_WIDTH-1:0] front_value;
  logic [DATA_WIDTH-1:0] back_value;
  logic [CNT_W-1:0]      entry_total;
  logic                  is_empty;
  stat_t                 status;
  logic [M_RAW_W-1:0]    m_raw;

  assign s_acc    = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign data_in  = s_tdata[DATA_WIDTH-1:0];

  // decode the operation into a row command
  always_comb begin
    ctrl       = '0;
    stat_next  = ST_OK;
    count_next = count;
    if (s_acc) begin
      case (s_tuser)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (vld[DEPTH-1]) begin
            stat_next = ST_PUSH_FULL;
          end else begin
            ctrl.shift_r  = (s_tuser == OP_PUSH_FRONT);
            ctrl.add_tail = (s_tuser == OP_PUSH_BACK);
            count_next    = count + CNT_W'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (!vld[0]) begin
            stat_next = ST_POP_EMPTY;
          end else begin
            ctrl.shift_l   = (s_tuser == OP_POP_FRONT);
            ctrl.drop_tail = (s_tuser == OP_POP_BACK);
            count_next     = count - CNT_W'(1);
          end
        end
        default: begin
          stat_next = ST_OK;
        end
      endcase
    end
  end

  // row of storage cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lv;
    logic                  lvld;
    logic [DATA_WIDTH-1:0] rv;
    logic                  rvld;

    if (i == 0) begin : g_first
      assign lv   = data_in;
      assign lvld = 1'b1;
    end else begin : g_mid_l
      assign lv   = val[i-1];
      assign lvld = vld[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv   = '0;
      assign rvld = 1'b0;
    end else begin : g_mid_r
      assign rv   = val[i+1];
      assign rvld = vld[i+1];
    end

    deq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .data_in   (data_in),
      .left_val  (lv),
      .left_vld  (lvld),
      .right_val (rv),
      .right_vld (rvld),
      .val       (val[i]),
      .vld       (vld[i]),
      .val_next  (val_next[i]),
      .vld_next  (vld_next[i])
    );
  end

  // the back is the one occupied cell whose upper neighbor is free
  assign last_mask = vld_next & ~{1'b0, vld_next[DEPTH-1:1]};

  always_comb begin
    back_sel = EMPTY_MARK;
    for (int i = 0; i < DEPTH; i++) begin
      if (last_mask[i]) begin
        back_sel = val_next[i];
      end
    end
  end

  assign front_sel = vld_next[0] ? val_next[0] : EMPTY_MARK;

  // entry counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_acc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (s_acc) begin
      front_value <= front_sel;
      back_value  <= back_sel;
      entry_total <= count_next;
      is_empty    <= !vld_next[0];
      status      <= stat_next;
    end
  end

  assign m_raw   = {status, is_empty, entry_total, back_value, front_value};
  assign m_tdata = M_TDATA_W'(m_raw);

  `include "double_ended_queue_top_macros.svh"

  `DEQ_ASSERT_ALWAYS(a_packed_row, (({1'b0, vld[DEPTH-1:1]} & ~vld) == '0), "occupied cells not packed from the front")
  `DEQ_ASSERT_ALWAYS(a_count_empty, ((count == '0) == !vld[0]), "entry count disagrees with front cell")
  `DEQ_ASSERT_NEXT(a_full_drop, (s_acc && vld[DEPTH-1] && (s_tuser == OP_PUSH_FRONT || s_tuser == OP_PUSH_BACK)), (status == ST_PUSH_FULL && $stable(vld)), "push on full not dropped")
  `DEQ_ASSERT_NEXT(a_result_valid, s_acc, (m_tvalid && entry_total == count), "no result after accepted word")

endmodule
